FILE: sv/voxel_ray_traversal_3d_assert.svh
// assertion macros for the voxel ray traversal block
// used by the top level only
`ifndef VOXEL_RAY_TRAVERSAL_3D_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_3D_ASSERT_SVH
// implication checked on every clock edge outside reset
`define VRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define VRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: sv/vrt_pkg.sv
// package for the voxel ray traversal block: widths, payload structs,
// controller/datapath command and status types; no dependencies
package vrt_pkg;
  localparam int CoordIntBits  = 16;
  localparam int CoordFracBits = 8;
  localparam int TimeFracBits  = 24;
  localparam int CoordW = CoordIntBits + CoordFracBits;
  localparam int TimeW  = TimeFracBits + 3;
  localparam int CellW  = CoordIntBits + 1;
  localparam int OutW   = 16;
  // dividend q << TimeFracBits fits in CoordFracBits+1+TimeFracBits bits
  localparam int DivNW  = CoordFracBits + 1 + TimeFracBits;
  localparam int DivDW  = CellW + CoordFracBits;
  localparam int DivCntW = $clog2(DivNW + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } req_t;

  typedef struct packed {
    logic signed [OutW-1:0] cell_x;
    logic signed [OutW-1:0] cell_y;
    logic signed [OutW-1:0] cell_z;
    logic                   more_cells;
    logic                   ray_ok;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;   // latch request, set up cells
    logic       div_start; // start one division
    logic [2:0] div_sel;   // 0..2 first time of axis, 3..5 spacing of axis
    logic       div_store; // write quotient
    logic       step;      // advance one cell
    logic       out_load;  // latch load result
    logic       out_step;  // latch step result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       div_done;
    logic [2:0] axis_move; // axes with nonzero difference
  } sts_t;
endpackage

FILE: sv/vrt_ctrl.sv
// controller state machine for the voxel ray traversal block
// depends on vrt_pkg
module vrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic          req_op_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  vrt_pkg::sts_t sts_i,
  output vrt_pkg::cmd_t cmd_o
);
  import vrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_RESULT
  } state_e;

  state_e     state_q;
  logic [2:0] sel_q;
  logic       rsp_valid_q;

  logic accept, free;
  assign free        = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && free;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;

  // datapath selects axis from sel; spacing entries follow first times
  logic needed;
  always_comb begin
    needed = sts_i.axis_move[(sel_q >= 3'd3) ? 2'(sel_q - 3'd3) : 2'(sel_q)];
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = sel_q;
    cmd_o.capture  = accept && (req_op_i == OP_LOAD);
    cmd_o.step     = accept && (req_op_i == OP_STEP);
    cmd_o.out_step = cmd_o.step;
    cmd_o.div_start = (state_q == S_DIV_GO) && needed;
    cmd_o.div_store = (state_q == S_DIV_WAIT) && sts_i.div_done;
    cmd_o.out_load  = (state_q == S_RESULT) && free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      // a new result is latched whenever the old one leaves or none is held
      if (cmd_o.out_step || cmd_o.out_load) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && req_op_i == OP_LOAD) begin
            state_q <= S_DIV_GO;
            sel_q   <= '0;
          end
        end
        S_DIV_GO: begin
          if (needed) state_q <= S_DIV_WAIT;
          else if (sel_q == 3'd5) state_q <= S_RESULT;
          else sel_q <= sel_q + 3'd1;
        end
        S_DIV_WAIT: begin
          if (sts_i.div_done) begin
            if (sel_q == 3'd5) state_q <= S_RESULT;
            else begin
              sel_q   <= sel_q + 3'd1;
              state_q <= S_DIV_GO;
            end
          end
        end
        S_RESULT: begin
          if (free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/vrt_div.sv
// restoring divider, one quotient bit per cycle
// depends on vrt_pkg
module vrt_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vrt_pkg::DivNW-1:0]    num_i,
  input  logic [vrt_pkg::DivDW-1:0]    den_i,
  output logic                         done_o,
  output logic [vrt_pkg::DivNW-1:0]    quo_o
);
  import vrt_pkg::*;

  logic [DivNW-1:0]   num_q;
  logic [DivDW:0]     rem_q;
  logic [DivDW-1:0]   den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic [DivDW:0]     trial;
  logic [DivDW+1:0]   diff;

  assign trial = {rem_q[DivDW-1:0], num_q[DivNW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign done_o = busy_q && (cnt_q == DivCntW'(1));
  // quotient bits shift into num_q from the bottom
  assign quo_o = {num_q[DivNW-2:0], ~diff[DivDW+1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(DivNW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= diff[DivDW+1] ? trial : diff[DivDW:0];
      num_q <= {num_q[DivNW-2:0], ~diff[DivDW+1]};
    end
  end
endmodule

FILE: sv/vrt_dp.sv
// datapath for the voxel ray traversal block: per-axis cells, times, step logic
// depends on vrt_pkg and vrt_div
module vrt_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vrt_pkg::req_t req_i,
  input  vrt_pkg::cmd_t cmd_i,
  output vrt_pkg::sts_t sts_o,
  output vrt_pkg::rsp_t rsp_o
);
  import vrt_pkg::*;

  logic signed [CellW-1:0]  cur_q [3];
  logic signed [CellW-1:0]  tgt_q [3];
  logic [1:0]               dir_q [3]; // bit1 negative, bit0 moving
  logic [CoordFracBits:0]   q_q   [3];
  logic [CellW-1:0]         n_q   [3];
  logic [TimeW-1:0]         tim_q [3];
  logic                     tinf_q[3];
  logic [TimeW-1:0]         spc_q [3];
  logic                     sinf_q[3];
  rsp_t                     rsp_q;

  logic signed [CoordW-1:0] s_in[3], e_in[3];
  assign s_in[0] = req_i.start_x; assign s_in[1] = req_i.start_y;
  assign s_in[2] = req_i.start_z;
  assign e_in[0] = req_i.end_x;   assign e_in[1] = req_i.end_y;
  assign e_in[2] = req_i.end_z;

  // arithmetic shift gives floor
  logic signed [CellW-1:0] c0[3], c1[3], dd[3];
  logic [CoordFracBits-1:0] f[3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c0[a] = CellW'(s_in[a] >>> CoordFracBits);
      c1[a] = CellW'(e_in[a] >>> CoordFracBits);
      dd[a] = c1[a] - c0[a];
      f[a]  = s_in[a][CoordFracBits-1:0];
    end
  end

  logic [2:0] mv, at_end;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mv[a]     = dir_q[a][0];
      at_end[a] = (cur_q[a] == tgt_q[a]);
    end
  end
  assign sts_o.axis_move = mv;

  // divider operand selection
  logic [1:0] ax;
  logic       is_spc;
  logic [DivNW-1:0] num;
  logic [DivDW-1:0] den;
  logic [DivNW-1:0] quo;
  logic             div_done;
  assign is_spc = (cmd_i.div_sel >= 3'd3);
  assign ax     = is_spc ? 2'(cmd_i.div_sel - 3'd3) : 2'(cmd_i.div_sel);
  always_comb begin
    if (is_spc) begin
      num = DivNW'(1) << TimeFracBits;
      den = DivDW'(n_q[ax]);
    end else begin
      num = DivNW'(q_q[ax]) << TimeFracBits;
      den = DivDW'(n_q[ax]) << CoordFracBits;
    end
  end

  vrt_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.div_start),
    .num_i(num), .den_i(den), .done_o(div_done), .quo_o(quo)
  );
  assign sts_o.div_done = div_done;

  // pick: smallest effective time, ties to higher axis
  logic [TimeW:0] et[3];
  logic [1:0]     pick;
  logic           more;
  always_comb begin
    for (int a = 0; a < 3; a++)
      et[a] = (tinf_q[a] || at_end[a]) ? {1'b1, {TimeW{1'b1}}} : {1'b0, tim_q[a]};
    if (et[0] < et[1]) pick = (et[0] < et[2]) ? 2'd0 : 2'd2;
    else               pick = (et[1] < et[2]) ? 2'd1 : 2'd2;
    more = ~&at_end;
  end

  logic [TimeW:0] tsum;
  assign tsum = {1'b0, tim_q[pick]} + {1'b0, spc_q[pick]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        cur_q[a] <= '0; tgt_q[a] <= '0; dir_q[a] <= '0;
        tim_q[a] <= '0; tinf_q[a] <= 1'b1;
        spc_q[a] <= '0; sinf_q[a] <= 1'b1;
        q_q[a] <= '0; n_q[a] <= '0;
      end
    end else if (cmd_i.capture) begin
      for (int a = 0; a < 3; a++) begin
        cur_q[a] <= c0[a];
        tgt_q[a] <= c1[a];
        dir_q[a] <= {dd[a][CellW-1], dd[a] != '0};
        n_q[a]   <= dd[a][CellW-1] ? CellW'(-dd[a]) : CellW'(dd[a]);
        if (dd[a][CellW-1])
          q_q[a] <= (f[a] == '0) ? (CoordFracBits+1)'(1) << CoordFracBits
                                 : {1'b0, f[a]};
        else
          q_q[a] <= ((CoordFracBits+1)'(1) << CoordFracBits) - {1'b0, f[a]};
        tinf_q[a] <= 1'b1; sinf_q[a] <= 1'b1;
        tim_q[a]  <= '0;   spc_q[a]  <= '0;
      end
    end else if (cmd_i.div_store) begin
      if (is_spc) begin
        spc_q[ax] <= TimeW'(quo); sinf_q[ax] <= 1'b0;
      end else begin
        tim_q[ax] <= TimeW'(quo); tinf_q[ax] <= 1'b0;
      end
    end else if (cmd_i.step && more) begin
      cur_q[pick] <= !dir_q[pick][0] ? cur_q[pick] :
                     dir_q[pick][1] ? cur_q[pick] - CellW'(1) : cur_q[pick] + CellW'(1);
      if (sinf_q[pick]) tinf_q[pick] <= 1'b1;
      else if (!tinf_q[pick])
        tim_q[pick] <= tsum[TimeW] ? {TimeW{1'b1}} : tsum[TimeW-1:0];
    end
  end

  logic ok;
  assign ok = |mv;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_step || cmd_i.out_load) begin
      rsp_q.cell_x <= OutW'(cur_q[0]);
      rsp_q.cell_y <= OutW'(cur_q[1]);
      rsp_q.cell_z <= OutW'(cur_q[2]);
      rsp_q.more_cells <= cmd_i.out_step ? more : 1'b0;
      rsp_q.ray_ok     <= cmd_i.out_load ? ok : 1'b0;
    end
  end
  assign rsp_o = rsp_q;
endmodule

FILE: sv/voxel_ray_traversal_3d.sv
// voxel ray traversal: a step result is registered in the cycle after the request is taken;
// a step request is accepted every cycle while no load runs and the result side keeps up
// load requests run up to six serial divisions (each a start, then one step per quotient bit)
// and then a result state; a division of an axis with no cell difference is skipped
// reset: asynchronous active low, clears cells and marks all times infinite
// depends on vrt_pkg, vrt_ctrl, vrt_dp, vrt_div
`include "voxel_ray_traversal_3d_assert.svh"
module voxel_ray_traversal_3d (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  vrt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output vrt_pkg::rsp_t rsp_o
);
  import vrt_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts requests, runs the load divisions, owns rsp_valid
  vrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o,
    .req_op_i(req_i.operation),
    .rsp_valid_o, .rsp_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // per-axis state, crossing compare, divider, result register
  vrt_dp u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

  // a stalled result is never overwritten
  `VRT_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i,
                  !(cmd.out_step || cmd.out_load))
  // a step request yields a result in the next cycle
  `VRT_ASSERT_NXT(a_step_rsp, clk_i, rst_ni, cmd.step, rsp_valid_o)
  // divider is started only while no request is taken
  `VRT_ASSERT_IMP(a_div_quiet, clk_i, rst_ni, cmd.div_start, !req_ready_o)
endmodule
